>>> hw/rtl/ccs_pkg.sv
// Shared types and constants for the character color shader.
// Used by char_color_shader_core; depends on nothing else.
`default_nettype none

package ccs_pkg;

   // Default viewport width in characters
   localparam int VIEW_WIDTH_DEF = 64;

   // Field and internal widths
   localparam int POS_W    = 10;
   localparam int TIME_W   = 48;
   localparam int CH_W     = 8;
   localparam int COLOR_W  = 24;
   localparam int SPAN_W   = 11;
   localparam int REP_W    = 7;
   localparam int SPEED_W  = 10;
   localparam int BUF_W    = 11;
   localparam int HUE_W    = 9;
   localparam int PROD_W   = 39;
   localparam int GNUM_W   = 18;

   // Pipeline length in register stages; each stage runs two micro steps
   localparam int NUM_STAGES = 24;

   // Time hue constants: one full hue turn per 360 s at one degree per second
   localparam longint TIME_MOD = 64'd360_000_000;
   localparam longint USEC_PER_SEC = 64'd1_000_000;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_MODE   = 3'd0,
      CSR_REPEAT = 3'd1,
      CSR_SPEED  = 3'd2,
      CSR_RTL    = 3'd3,
      CSR_COLOR_A = 3'd4,
      CSR_COLOR_B = 3'd5,
      CSR_BUFSIZE = 3'd6,
      CSR_SPARE  = 3'd7
   } csr_index_type;

   // Shader modes
   typedef enum logic [2:0] {
      MODE_STATIC   = 3'd0,
      MODE_RAINBOW  = 3'd1,
      MODE_SWEEP    = 3'd2,
      MODE_HUE      = 3'd3,
      MODE_GRADIENT = 3'd4,
      MODE_WHITE5   = 3'd5,
      MODE_WHITE6   = 3'd6,
      MODE_WHITE7   = 3'd7
   } mode_type;

   // Payload carried down the pipeline
   typedef struct packed {
      logic [SPAN_W-1:0]            p;
      logic [TIME_W-1:0]            t;
      logic [PROD_W-1:0]            y;
      logic [HUE_W-1:0]             th;
      logic [HUE_W-1:0]             pxs;
      logic [2:0][GNUM_W-1:0]       num;
      logic [2:0][CH_W-1:0]         quo;
      logic [HUE_W-1:0]             hue;
      logic [2:0]                   sector;
      logic [5:0]                   frac;
      logic [2:0][CH_W-1:0]         rgb;
   } stage_type;

endpackage

`default_nettype wire

>>> hw/rtl/char_color_shader_core.sv
// Character color shader: pipelined position/time to RGB color generator.
// Depends on ccs_pkg for widths, codes and the pipeline payload type.
`default_nettype none

// Takes one transaction per cycle unless the result is held, and returns its color,
// one result per input in order. The pipeline depth is set by the time-hue path:
// the timestamp is reduced modulo 360e6 one conditional subtract at a time, scaled
// by the speed, reduced again and divided by 1e6 bit by bit, two steps per stage.
// A stall on the result side freezes the whole pipeline; nothing is dropped.
// Configuration writes are taken at any time and must be made while no
// transaction is in flight.
module char_color_shader_core
   import ccs_pkg::*;
#(
   parameter int VIEW_WIDTH = VIEW_WIDTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [POS_W-1:0]    req_char_position,
   input  wire logic [TIME_W-1:0]   req_time_us,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [CH_W-1:0]          rsp_red,
   output logic [CH_W-1:0]          rsp_green,
   output logic [CH_W-1:0]          rsp_blue,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [2:0]          csr_index,
   input  wire logic [COLOR_W-1:0]  csr_data
);

   localparam int LAST = NUM_STAGES - 1;

   // Configuration registers
   mode_type               mode_ff;
   logic [SPEED_W-1:0]     speed_ff;
   logic                   rtl_ff;
   logic [COLOR_W-1:0]     color_a_ff;
   logic [COLOR_W-1:0]     color_b_ff;
   logic [BUF_W-1:0]       bufsize_ff;

   // Derived span values, loaded from the tables with the repeat count
   logic [SPAN_W-1:0]      span_ff;
   logic [HUE_W-1:0]       step_ff;
   logic [9:0]             dist_ff;

   logic [SPAN_W-1:0]      span_tab [128];
   logic [HUE_W-1:0]       step_tab [128];
   logic [CH_W-1:0]        rise_tab [61];

   stage_type              pipe_ff [NUM_STAGES];
   stage_type              pipe_in [NUM_STAGES];
   logic                   valid_ff [NUM_STAGES];
   stage_type              entry;
   logic                   advance;

   // Span and hue step per repeat count
   for (genvar gi = 0; gi < 128; gi++) begin : g_span
      localparam int REP = (gi == 0) ? 1 : gi;
      localparam int SP  = VIEW_WIDTH / REP;
      localparam int SPC = (SP == 0) ? 1 : SP;
      assign span_tab[gi] = SPAN_W'(SPC);
      assign step_tab[gi] = HUE_W'(360 / SPC);
   end

   // Rising edge of one hue sector, rounded to nearest
   for (genvar gi = 0; gi < 61; gi++) begin : g_rise
      localparam int RV = (255 * gi + 30) / 60;
      assign rise_tab[gi] = CH_W'(RV);
   end

   // Configuration write port
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_STATIC;
         speed_ff   <= SPEED_W'(1);
         rtl_ff     <= 1'b0;
         color_a_ff <= 24'hFFFFFF;
         color_b_ff <= 24'h000000;
         bufsize_ff <= BUF_W'(64);
         span_ff    <= span_tab[REP_W'(1)];
         step_ff    <= step_tab[REP_W'(1)];
         dist_ff    <= 10'(span_tab[REP_W'(1)] - SPAN_W'(1));
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:    mode_ff    <= mode_type'(csr_data[2:0]);
            CSR_REPEAT: begin
               span_ff <= span_tab[csr_data[REP_W-1:0]];
               step_ff <= step_tab[csr_data[REP_W-1:0]];
               dist_ff <= 10'(span_tab[csr_data[REP_W-1:0]] - SPAN_W'(1));
            end
            CSR_SPEED:   speed_ff   <= csr_data[SPEED_W-1:0];
            CSR_RTL:     rtl_ff     <= csr_data[0];
            CSR_COLOR_A: color_a_ff <= csr_data;
            CSR_COLOR_B: color_b_ff <= csr_data;
            CSR_BUFSIZE: bufsize_ff <= csr_data[BUF_W-1:0];
            CSR_SPARE:   ;
         endcase
      end
   end

   // One micro step of the schedule; j picks the operation
   function automatic stage_type micro_step(input int j, input stage_type r);
      stage_type          o;
      logic [63:0]        lim;
      logic [21:0]        plim;
      logic [GNUM_W-1:0]  glim;
      logic [9:0]         hsum;
      logic [9:0]         xn;
      logic [CH_W-1:0]    ach;
      logic [CH_W-1:0]    bch;
      logic [CH_W-1:0]    rise;
      logic [CH_W-1:0]    fall;
      int                 k;
      o = r;
      // Reduce the timestamp modulo 360e6
      if (j < 20) begin
         k = 19 - j;
         lim = TIME_MOD << k;
         if ({16'b0, o.t} >= lim) o.t = o.t - lim[TIME_W-1:0];
      end
      // Reduce the position modulo the span
      if (j <= 10) begin
         k = 10 - j;
         plim = {11'b0, span_ff} << k;
         if ({11'b0, o.p} >= plim) o.p = o.p - plim[SPAN_W-1:0];
      end
      // Positional hue and gradient numerators
      if (j == 12) begin
         xn = o.p[9:0];
         o.pxs = HUE_W'({9'b0, o.p} * {11'b0, step_ff});
         for (int c = 0; c < 3; c++) begin
            ach = color_a_ff[8*(2-c) +: 8];
            bch = color_b_ff[8*(2-c) +: 8];
            o.num[c] = ({10'b0, ach} * {8'b0, 10'(dist_ff - xn)})
                     + ({10'b0, bch} * {8'b0, xn})
                     + {8'b0, 1'b0, dist_ff[9:1]};
            o.quo[c] = '0;
         end
      end
      // Gradient division, one quotient bit per step
      if (j >= 14 && j <= 21) begin
         k = 21 - j;
         glim = {8'b0, dist_ff} << k;
         for (int c = 0; c < 3; c++) begin
            if (o.num[c] >= glim) begin
               o.num[c] = o.num[c] - glim;
               o.quo[c][k] = 1'b1;
            end
         end
      end
      // Scale by speed
      if (j == 20) begin
         o.y = {29'b0, speed_ff} * {10'b0, o.t[28:0]};
      end
      // Reduce the scaled time modulo 360e6
      if (j >= 22 && j <= 31) begin
         k = 31 - j;
         lim = TIME_MOD << k;
         if ({25'b0, o.y} >= lim) o.y = o.y - lim[PROD_W-1:0];
      end
      // Whole degrees: divide by 1e6
      if (j >= 32 && j <= 40) begin
         k = 40 - j;
         lim = USEC_PER_SEC << k;
         if (j == 32) o.th = '0;
         if ({25'b0, o.y} >= lim) begin
            o.y = o.y - lim[PROD_W-1:0];
            o.th[k] = 1'b1;
         end
      end
      // Pick the hue for the mode
      if (j == 42) begin
         hsum = {1'b0, o.pxs} + {1'b0, o.th};
         if (hsum >= 10'd360) hsum = hsum - 10'd360;
         unique case (mode_ff)
            MODE_RAINBOW: o.hue = o.pxs;
            MODE_SWEEP:   o.hue = hsum[HUE_W-1:0];
            MODE_HUE:     o.hue = o.th;
            default:      o.hue = '0;
         endcase
      end
      // Split the hue into sector and offset
      if (j == 44) begin
         priority if (o.hue >= 9'd300) begin
            o.sector = 3'd5; o.frac = 6'(o.hue - 9'd300);
         end else if (o.hue >= 9'd240) begin
            o.sector = 3'd4; o.frac = 6'(o.hue - 9'd240);
         end else if (o.hue >= 9'd180) begin
            o.sector = 3'd3; o.frac = 6'(o.hue - 9'd180);
         end else if (o.hue >= 9'd120) begin
            o.sector = 3'd2; o.frac = 6'(o.hue - 9'd120);
         end else if (o.hue >= 9'd60) begin
            o.sector = 3'd1; o.frac = 6'(o.hue - 9'd60);
         end else begin
            o.sector = 3'd0; o.frac = 6'(o.hue);
         end
      end
      // Form the final color
      if (j == 46) begin
         rise = rise_tab[o.frac];
         fall = rise_tab[6'(6'd60 - o.frac)];
         unique case (mode_ff)
            MODE_STATIC: begin
               o.rgb = {color_a_ff[23:16], color_a_ff[15:8], color_a_ff[7:0]};
            end
            MODE_RAINBOW, MODE_SWEEP, MODE_HUE: begin
               unique case (o.sector)
                  3'd0:    o.rgb = {8'd255, rise, 8'd0};
                  3'd1:    o.rgb = {fall, 8'd255, 8'd0};
                  3'd2:    o.rgb = {8'd0, 8'd255, rise};
                  3'd3:    o.rgb = {8'd0, fall, 8'd255};
                  3'd4:    o.rgb = {rise, 8'd0, 8'd255};
                  default: o.rgb = {8'd255, 8'd0, fall};
               endcase
            end
            MODE_GRADIENT: begin
               if (dist_ff == '0) begin
                  o.rgb = {color_a_ff[23:16], color_a_ff[15:8], color_a_ff[7:0]};
               end else begin
                  o.rgb = {o.quo[0], o.quo[1], o.quo[2]};
               end
            end
            default: o.rgb = {8'd255, 8'd255, 8'd255};
         endcase
      end
      return o;
   endfunction

   // Build the entry record; left-to-right sweep measures from the buffer end
   always_comb begin
      entry = '0;
      entry.t = req_time_us;
      if (mode_ff == MODE_SWEEP && !rtl_ff) begin
         entry.p = BUF_W'(bufsize_ff - {1'b0, req_char_position});
      end else begin
         entry.p = {1'b0, req_char_position};
      end
   end

   // Stage logic: two micro steps per stage
   always_comb begin
      for (int s = 0; s < NUM_STAGES; s++) begin
         pipe_in[s] = (s == 0) ? entry : pipe_ff[(s == 0) ? 0 : s - 1];
         pipe_in[s] = micro_step(2 * s, pipe_in[s]);
         pipe_in[s] = micro_step(2 * s + 1, pipe_in[s]);
      end
   end

   // Advance the whole pipeline unless the result is held
   assign advance   = !valid_ff[LAST] || rsp_ready;
   assign req_ready = advance && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STAGES; s++) valid_ff[s] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_valid;
         for (int s = 1; s < NUM_STAGES; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < NUM_STAGES; s++) pipe_ff[s] <= pipe_in[s];
      end
   end

   // Drive the result channel from the last stage
   assign rsp_valid = valid_ff[LAST];
   assign rsp_red   = pipe_ff[LAST].rgb[2];
   assign rsp_green = pipe_ff[LAST].rgb[1];
   assign rsp_blue  = pipe_ff[LAST].rgb[0];

   // Held result keeps its color
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pipe_ff[LAST].rgb))
      else $error("held result changed");

   // Valid bits move one stage per advancing cycle
   assert property (@(posedge clock) disable iff (reset)
      advance |=> valid_ff[LAST] == $past(valid_ff[LAST-1]))
      else $error("valid bit lost or repeated");

   // Time hue is a whole degree below one turn
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[20] |-> pipe_ff[20].th < 9'd360)
      else $error("time hue out of range");

endmodule

`default_nettype wire
